@@ rtl/core/intel_hex_record_parser_top_assert.svh @@
// Assertion macros used by the hex record parser back end (ihex_back).
// Needs clk and rst_n in scope at the point of use.
`ifndef INTEL_HEX_RECORD_PARSER_TOP_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define IHEX_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define IHEX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ihex_pkg.sv @@
// Shared types and constants for the hex record parser.
// No dependencies; used by every module under rtl/core.
package ihex_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] COLON_CHAR  = 8'h3A;
  localparam logic [7:0] DIGIT_BIAS  = 8'd48;
  localparam logic [7:0] LOWER_BIAS  = 8'd87;
  localparam logic [7:0] UPPER_BIAS  = 8'd55;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CHECKSUM  = 3'd1,
    ST_EXP_HEX   = 3'd2,
    ST_EXP_COLON = 3'd3,
    ST_EOF       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CLS_HEX   = 2'd0,
    CLS_COLON = 2'd1,
    CLS_OTHER = 2'd2,
    CLS_EOI   = 2'd3
  } char_cls_t;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [7:0]  record_length;
    logic [15:0] load_offset;
    logic [7:0]  record_type;
    logic [2:0]  status;
  } out_word_t;

  typedef struct packed {
    char_cls_t  cls;
    logic [3:0] nib;
  } token_t;

  typedef struct packed {
    logic   valid;
    token_t token;
  } queue_head_t;

endpackage

@@ rtl/core/ihex_front.sv @@
// Front end: classifies each input word into a token and queues it.
// Depends on ihex_pkg.
module ihex_front #(
  parameter int unsigned QDepth = ihex_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ihex_pkg::in_word_t  in_data,
  output ihex_pkg::queue_head_t q_head,
  input  logic                q_pop
);

  localparam int unsigned PW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CW = $clog2(QDepth + 1);

  ihex_pkg::token_t q_mem [QDepth];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  ihex_pkg::token_t tok;
  logic push;
  logic pop;

  always_comb begin
    tok.cls = ihex_pkg::CLS_OTHER;
    tok.nib = 4'd0;
    if (in_data.end_of_input) begin
      tok.cls = ihex_pkg::CLS_EOI;
    end else if (in_data.ch == ihex_pkg::COLON_CHAR) begin
      tok.cls = ihex_pkg::CLS_COLON;
    end else if (in_data.ch >= "0" && in_data.ch <= "9") begin
      tok.cls = ihex_pkg::CLS_HEX;
      tok.nib = 4'(in_data.ch - ihex_pkg::DIGIT_BIAS);
    end else if (in_data.ch >= "a" && in_data.ch <= "f") begin
      tok.cls = ihex_pkg::CLS_HEX;
      tok.nib = 4'(in_data.ch - ihex_pkg::LOWER_BIAS);
    end else if (in_data.ch >= "A" && in_data.ch <= "F") begin
      tok.cls = ihex_pkg::CLS_HEX;
      tok.nib = 4'(in_data.ch - ihex_pkg::UPPER_BIAS);
    end
  end

  assign in_stall     = (cnt_r == CW'(QDepth));
  assign push         = in_valid && !in_stall;
  assign q_head.valid = (cnt_r != '0);
  assign q_head.token = q_mem[rd_ptr_r];
  assign pop          = q_pop && q_head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDepth - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDepth - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= tok;
    end
  end

endmodule

@@ rtl/core/ihex_back.sv @@
// Back end: record parser state machine and output register.
// Depends on ihex_pkg and the assertion macro header.
`include "intel_hex_record_parser_top_assert.svh"

module ihex_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ihex_pkg::queue_head_t q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ihex_pkg::out_word_t   out_data
);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_OFS  = 3'd2,
    PH_TYPE = 3'd3,
    PH_DATA = 3'd4,
    PH_SUM  = 3'd5
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        hi_r, hi_nxt;
  logic [3:0]  pend_r, pend_nxt;
  logic        ofs_cnt_r, ofs_cnt_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] ofs_r, ofs_nxt;
  logic [7:0]  typ_r, typ_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  dcnt_r, dcnt_nxt;
  logic        err_r, err_nxt;
  logic        out_valid_r, out_valid_nxt;
  ihex_pkg::out_word_t out_r, out_nxt;

  logic       emit;
  logic [7:0] byte_val;
  logic [7:0] sum_add;
  logic [7:0] dcnt_inc;
  ihex_pkg::token_t tok;

  assign tok      = q_head.token;
  assign q_pop    = q_head.valid && (!out_valid_r || !out_stall);
  assign byte_val = {pend_r, tok.nib};
  assign sum_add  = sum_r + byte_val;
  assign dcnt_inc = dcnt_r + 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    hi_nxt      = hi_r;
    pend_nxt    = pend_r;
    ofs_cnt_nxt = ofs_cnt_r;
    len_nxt     = len_r;
    ofs_nxt     = ofs_r;
    typ_nxt     = typ_r;
    sum_nxt     = sum_r;
    dcnt_nxt    = dcnt_r;
    err_nxt     = err_r;
    emit        = 1'b0;
    out_nxt.kind          = ihex_pkg::KIND_END;
    out_nxt.data_byte     = 8'd0;
    out_nxt.byte_index    = 8'd0;
    out_nxt.record_length = len_r;
    out_nxt.load_offset   = ofs_r;
    out_nxt.record_type   = typ_r;
    out_nxt.status        = ihex_pkg::ST_OK;

    if (q_pop && !err_r) begin
      if (phase_r == PH_HUNT) begin
        if (tok.cls == ihex_pkg::CLS_EOI) begin
          emit           = 1'b1;
          err_nxt        = 1'b1;
          out_nxt.status = ihex_pkg::ST_EOF;
        end else if (tok.cls == ihex_pkg::CLS_COLON) begin
          phase_nxt   = PH_LEN;
          hi_nxt      = 1'b0;
          pend_nxt    = 4'd0;
          ofs_cnt_nxt = 1'b0;
          len_nxt     = 8'd0;
          ofs_nxt     = 16'd0;
          typ_nxt     = 8'd0;
          sum_nxt     = 8'd0;
          dcnt_nxt    = 8'd0;
        end else if (tok.cls == ihex_pkg::CLS_HEX) begin
          emit           = 1'b1;
          err_nxt        = 1'b1;
          out_nxt.status = ihex_pkg::ST_EXP_COLON;
        end
      end else if (tok.cls != ihex_pkg::CLS_HEX) begin
        emit           = 1'b1;
        err_nxt        = 1'b1;
        out_nxt.status = ihex_pkg::ST_EXP_HEX;
      end else if (!hi_r) begin
        pend_nxt = tok.nib;
        hi_nxt   = 1'b1;
      end else begin
        hi_nxt   = 1'b0;
        pend_nxt = 4'd0;
        case (phase_r)
          PH_LEN: begin
            len_nxt     = byte_val;
            sum_nxt     = sum_add;
            ofs_cnt_nxt = 1'b0;
            phase_nxt   = PH_OFS;
          end
          PH_OFS: begin
            sum_nxt = sum_add;
            if (!ofs_cnt_r) begin
              ofs_nxt     = {byte_val, 8'd0};
              ofs_cnt_nxt = 1'b1;
            end else begin
              ofs_nxt     = {ofs_r[15:8], byte_val};
              ofs_cnt_nxt = 1'b0;
              phase_nxt   = PH_TYPE;
            end
          end
          PH_TYPE: begin
            typ_nxt   = byte_val;
            sum_nxt   = sum_add;
            dcnt_nxt  = 8'd0;
            phase_nxt = (len_r == 8'd0) ? PH_SUM : PH_DATA;
          end
          PH_DATA: begin
            sum_nxt            = sum_add;
            dcnt_nxt           = dcnt_inc;
            if (dcnt_inc == len_r) begin
              phase_nxt = PH_SUM;
            end
            emit               = 1'b1;
            out_nxt.kind       = ihex_pkg::KIND_DATA;
            out_nxt.data_byte  = byte_val;
            out_nxt.byte_index = dcnt_r;
          end
          default: begin
            phase_nxt = PH_HUNT;
            emit      = 1'b1;
            if (sum_add != 8'd0) begin
              err_nxt        = 1'b1;
              out_nxt.status = ihex_pkg::ST_CHECKSUM;
            end
          end
        endcase
      end
    end

    out_valid_nxt = q_pop ? emit : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      hi_r        <= 1'b0;
      pend_r      <= 4'd0;
      ofs_cnt_r   <= 1'b0;
      len_r       <= 8'd0;
      ofs_r       <= 16'd0;
      typ_r       <= 8'd0;
      sum_r       <= 8'd0;
      dcnt_r      <= 8'd0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      hi_r        <= hi_nxt;
      pend_r      <= pend_nxt;
      ofs_cnt_r   <= ofs_cnt_nxt;
      len_r       <= len_nxt;
      ofs_r       <= ofs_nxt;
      typ_r       <= typ_nxt;
      sum_r       <= sum_nxt;
      dcnt_r      <= dcnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (q_pop && emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `IHEX_ASSERT_NEXT(a_err_sticky, err_r, err_r, "error latch cleared without reset")
  `IHEX_ASSERT_NEXT(a_no_out_after_err, err_r && !out_valid_r, !out_valid_r,
                    "result emitted after error latched")
  `IHEX_ASSERT_SAME(a_data_ok, out_valid_r && out_r.kind == ihex_pkg::KIND_DATA,
                    out_r.status == ihex_pkg::ST_OK, "data word with nonzero status")
  `IHEX_ASSERT_SAME(a_data_len, phase_r == PH_DATA, len_r != 8'd0,
                    "data phase entered with zero length")

endmodule

@@ rtl/core/intel_hex_record_parser_top.sv @@
// Hex record parser: one character in, at most one result word out, per unstalled cycle.
// Result path from input accept: queue write, then parser register.
// Throughput: 1 word per cycle when not stalled, set by the parser step in the back end.
// Queue holds QDepth words, so either side may stall without stopping the other.
// Reset: synchronous active low rst_n clears queue, parser state and error latch at once.
// Depends on ihex_pkg, ihex_front and ihex_back.
module intel_hex_record_parser_top #(
  parameter int unsigned QDepth = ihex_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ihex_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ihex_pkg::out_word_t out_data
);

  ihex_pkg::queue_head_t q_head;
  logic q_pop;

  ihex_front #(
    .QDepth (QDepth)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  ihex_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for intel_hex_record_parser_top: streams hex file text,
// predicts every result word and compares it with what the block returns.
// Depends on ihex_pkg and the parser RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_HUNT, PH_LEN, PH_OFS, PH_TYPE, PH_DATA, PH_SUM
  } rec_phase_t;

  typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_RAMP} fill_t;

  typedef enum logic [2:0] {
    END_EOF, END_STRAY_DIGIT, END_BAD_CHAR, END_EOI_IN_RECORD, END_BAD_SUM
  } stream_end_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ihex_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ihex_pkg::out_word_t out_data;

  intel_hex_record_parser_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  ihex_pkg::in_word_t  pending_chars[$];
  ihex_pkg::out_word_t expected_results[$];
  int         accepted_chars = 0;
  int         total_chars = 0;
  int         mismatch_count = 0;
  bit         in_took = 1'b0;
  bit         out_took = 1'b0;
  bit         in_burst = 1'b0;
  bit         out_burst = 1'b0;
  bit         hold_out = 1'b0;
  int         in_gap = 0;
  int         out_gap = 0;

  // parser prediction state
  rec_phase_t ph = PH_HUNT;
  bit         hi_held = 1'b0;
  logic [3:0] hi_nib = '0;
  bit         ofs_second = 1'b0;
  logic [7:0] hdr_len = '0;
  logic [15:0] hdr_ofs = '0;
  logic [7:0] hdr_type = '0;
  logic [7:0] byte_sum = '0;
  logic [7:0] n_data = '0;
  bit         err_latched = 1'b0;

  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - ihex_pkg::DIGIT_BIAS);
    if (c >= "a" && c <= "f") return 5'(c - ihex_pkg::LOWER_BIAS);
    if (c >= "A" && c <= "F") return 5'(c - ihex_pkg::UPPER_BIAS);
    return 5'd16;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return ihex_pkg::DIGIT_BIAS + n;
    if ($urandom_range(0, 1) == 0) return ihex_pkg::UPPER_BIAS + n;
    return ihex_pkg::LOWER_BIAS + n;
  endfunction

  function automatic string show(ihex_pkg::out_word_t w);
    return $sformatf("kind=%0d byte=%02h idx=%0d len=%0d ofs=%04h type=%02h status=%0d",
                     w.kind, w.data_byte, w.byte_index, w.record_length, w.load_offset,
                     w.record_type, w.status);
  endfunction

  task automatic push_result(logic kind, logic [7:0] data, logic [7:0] idx,
                             ihex_pkg::status_t st);
    ihex_pkg::out_word_t r;
    r.kind          = kind;
    r.data_byte     = data;
    r.byte_index    = idx;
    r.record_length = hdr_len;
    r.load_offset   = hdr_ofs;
    r.record_type   = hdr_type;
    r.status        = st;
    expected_results.push_back(r);
  endtask

  task automatic raise_error(ihex_pkg::status_t st);
    err_latched = 1'b1;
    push_result(ihex_pkg::KIND_END, 8'h00, 8'h00, st);
  endtask

  task automatic parse_char(ihex_pkg::in_word_t w);
    logic [4:0] nib;
    logic [7:0] b;
    if (err_latched) return;
    if (ph == PH_HUNT) begin
      if (w.end_of_input) begin
        raise_error(ihex_pkg::ST_EOF);
      end else if (w.ch == ihex_pkg::COLON_CHAR) begin
        ph = PH_LEN;
        hi_held = 1'b0;
        hi_nib = '0;
        ofs_second = 1'b0;
        hdr_len = '0;
        hdr_ofs = '0;
        hdr_type = '0;
        byte_sum = '0;
        n_data = '0;
      end else begin
        nib = hex_nibble(w.ch);
        if (!nib[4]) raise_error(ihex_pkg::ST_EXP_COLON);
      end
      return;
    end
    nib = w.end_of_input ? 5'd16 : hex_nibble(w.ch);
    if (nib[4]) begin
      raise_error(ihex_pkg::ST_EXP_HEX);
      return;
    end
    if (!hi_held) begin
      hi_nib = nib[3:0];
      hi_held = 1'b1;
      return;
    end
    hi_held = 1'b0;
    b = {hi_nib, nib[3:0]};
    hi_nib = '0;
    byte_sum = byte_sum + b;
    case (ph)
      PH_LEN: begin
        hdr_len = b;
        ofs_second = 1'b0;
        ph = PH_OFS;
      end
      PH_OFS: begin
        if (!ofs_second) begin
          hdr_ofs = {b, 8'h00};
          ofs_second = 1'b1;
        end else begin
          hdr_ofs[7:0] = b;
          ofs_second = 1'b0;
          ph = PH_TYPE;
        end
      end
      PH_TYPE: begin
        hdr_type = b;
        n_data = '0;
        ph = (hdr_len == 0) ? PH_SUM : PH_DATA;
      end
      PH_DATA: begin
        push_result(ihex_pkg::KIND_DATA, b, n_data, ihex_pkg::ST_OK);
        n_data = n_data + 8'd1;
        if (n_data == hdr_len) ph = PH_SUM;
      end
      default: begin
        ph = PH_HUNT;
        if (byte_sum != 0) raise_error(ihex_pkg::ST_CHECKSUM);
        else push_result(ihex_pkg::KIND_END, 8'h00, 8'h00, ihex_pkg::ST_OK);
      end
    endcase
  endtask

  // stimulus builders
  task automatic put_char(logic [7:0] c);
    pending_chars.push_back({c, 1'b0});
  endtask

  task automatic put_hex(logic [7:0] b);
    put_char(hex_char(b[7:4]));
    put_char(hex_char(b[3:0]));
  endtask

  task automatic put_junk(int n);
    logic [7:0] c;
    logic [4:0] nib;
    for (int i = 0; i < n; i++) begin
      do begin
        c = 8'($urandom);
        nib = hex_nibble(c);
      end while (!nib[4] || c == ihex_pkg::COLON_CHAR);
      put_char(c);
    end
  endtask

  task automatic put_record(logic [7:0] len, logic [15:0] ofs, logic [7:0] typ, fill_t fill,
                            bit bad_sum);
    logic [7:0] s;
    logic [7:0] d;
    s = len + ofs[15:8] + ofs[7:0] + typ;
    put_char(ihex_pkg::COLON_CHAR);
    put_hex(len);
    put_hex(ofs[15:8]);
    put_hex(ofs[7:0]);
    put_hex(typ);
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: d = 8'h00;
        FILL_ONES: d = 8'hFF;
        FILL_RAMP: d = 8'(i);
        default: begin
          case ($urandom_range(0, 15))
            0: d = 8'h00;
            1: d = 8'hFF;
            default: d = 8'($urandom);
          endcase
        end
      endcase
      s = s + d;
      put_hex(d);
    end
    d = 8'h00 - s;
    if (bad_sum) d = d + 8'($urandom_range(1, 255));
    put_hex(d);
  endtask

  task automatic put_random_record(logic [7:0] len, bit bad_sum);
    logic [15:0] ofs;
    logic [7:0] typ;
    fill_t fill;
    case ($urandom_range(0, 7))
      0: ofs = 16'h0000;
      1: ofs = 16'hFFFF;
      default: ofs = 16'($urandom);
    endcase
    typ = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
    fill = ($urandom_range(0, 15) == 0) ? fill_t'($urandom_range(1, 3)) : FILL_RANDOM;
    put_record(len, ofs, typ, fill, bad_sum);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_chars.size() > 0) begin
        in_data <= pending_chars.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 49) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (out_took) begin
      if ($urandom_range(0, 49) == 0) out_burst = !out_burst;
      out_gap = out_burst ? 0 : $urandom_range(0, 6);
    end else if (out_gap > 0) begin
      out_gap--;
    end
    out_stall <= hold_out || (out_gap != 0);
  end

  // monitor
  always @(posedge clk) begin
    ihex_pkg::out_word_t want;
    in_took = 1'b0;
    out_took = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        accepted_chars++;
        parse_char(in_data);
      end
      if (out_valid && !out_stall) begin
        out_took = 1'b1;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected word: %s", show(out_data));
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: expected %s", show(want));
              $display("          actual   %s", show(out_data));
            end
          end
        end
      end
    end
  end

  // long receiver hold-off so the input side backs up
  initial begin
    while (accepted_chars < 300) @(posedge clk);
    hold_out = 1'b1;
    repeat (250) @(posedge clk);
    hold_out = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    bit          big_done;
    int          pick;
    int          start;
    int          cut;
    logic [7:0]  len;
    stream_end_t finish_with;
    big_done = 1'b0;

    put_junk(2);
    put_record(8'd0, 16'h0000, 8'h00, FILL_RANDOM, 1'b0);
    put_char(8'h0D);
    put_char(8'h0A);
    put_record(8'd1, 16'hFFFF, 8'hFF, FILL_ONES, 1'b0);

    while (pending_chars.size() < 1050) begin
      pick = $urandom_range(0, 15);
      if (!big_done && (pick == 0 || pending_chars.size() > 700)) begin
        len = 8'd255;
        big_done = 1'b1;
      end else if (pick == 1) begin
        len = 8'($urandom_range(17, 80));
      end else begin
        len = 8'($urandom_range(0, 16));
      end
      put_random_record(len, 1'b0);
      put_junk($urandom_range(0, 3));
    end

    // errors latch until reset, so exactly one ends the stream
    finish_with = stream_end_t'($urandom_range(0, 4));
    case (finish_with)
      END_EOF: pending_chars.push_back({8'($urandom), 1'b1});
      END_STRAY_DIGIT: put_char(hex_char(4'($urandom)));
      END_BAD_CHAR, END_EOI_IN_RECORD: begin
        start = pending_chars.size();
        put_random_record(8'($urandom_range(0, 8)), 1'b0);
        cut = $urandom_range(1, pending_chars.size() - start - 1);
        while (pending_chars.size() > start + cut) void'(pending_chars.pop_back());
        if (finish_with == END_EOI_IN_RECORD) pending_chars.push_back({8'($urandom), 1'b1});
        else if ($urandom_range(0, 3) == 0) put_char(ihex_pkg::COLON_CHAR);
        else put_junk(1);
      end
      default: put_random_record(8'($urandom_range(0, 8)), 1'b1);
    endcase
    for (int i = 0; i < 16; i++) pending_chars.push_back({8'($urandom), 1'($urandom)});
    total_chars = pending_chars.size();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_chars < total_chars || expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
